// File: sv/meaq_pkg.sv
// Shared types and constants for the pointer event aggregator queue.
// No dependencies; imported by every module of the block.
package meaq_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int BUTTON_COUNT = 8;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 280;
    localparam int M_TUSER_W = 1;

    typedef enum logic [2:0] {
        ACT_MOTION  = 3'd0,
        ACT_BUTTON  = 3'd1,
        ACT_WHEEL   = 3'd2,
        ACT_SET_POS = 3'd3,
        ACT_POLL    = 3'd4
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [BUTTON_COUNT-1:0] btn_mask_t;

    typedef struct packed {
        logic [7:0]  wheel;
        logic [7:0]  buttons;
        logic [31:0] dy;
        logic [31:0] dx;
        logic [31:0] y;
        logic [31:0] x;
    } ring_entry_t;

    typedef struct packed {
        logic        we;
        ptr_t        waddr;
        ring_entry_t wdata;
        logic        re;
        ptr_t        raddr;
    } ram_req_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] move_dx;
        logic signed [31:0] move_dy;
        logic [7:0]         button_index;
        logic               button_down;
        logic signed [7:0]  wheel_step;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } item_t;

    // Member order is MSB first, so event_x ends up in the lowest bits.
    typedef struct packed {
        logic [7:0]         buttons_now;
        logic signed [31:0] last_dy;
        logic signed [31:0] last_dx;
        logic signed [31:0] current_y;
        logic signed [31:0] current_x;
        logic [7:0]         event_buttons;
        logic signed [7:0]  event_wheel;
        logic signed [31:0] event_dy;
        logic signed [31:0] event_dx;
        logic signed [31:0] event_y;
        logic signed [31:0] event_x;
    } result_t;

endpackage

// File: sv/mouse_event_aggregator_queue_top.sv
// Top level of the pointer event aggregator queue: stream ports, output register.
// Depends on meaq_pkg, meaq_core and meaq_ring_ram.
//
//  port group | dir | tdata / tuser contents
//  s_*        | in  | one report or poll item, action in tuser
//  m_*        | out | one result item per input item, event_valid in tuser
//
// Each item has an accept step and a response step: the accept cycle updates state and
// issues the ring access; in ST_RESP the registered ring read data is ready and the
// output register loads. Back-pressure on m_* holds the block in ST_RESP.
// The output register lets the next item be accepted while a result waits.
// Synchronous active-low reset empties the ring; entries need no clearing.
module mouse_event_aggregator_queue_top
    import meaq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // move_dx, move_dy, button_index, button_down, wheel_step, new_x, new_y, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // event_x, event_y, event_dx, event_dy, event_wheel, event_buttons,
    // current_x, current_y, last_dx, last_dy, buttons_now
    output logic [M_TDATA_W-1:0] m_tdata,
    // event_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    item_t       item;
    ram_req_t    ram_req;
    ring_entry_t ram_rdata;
    logic        res_valid;
    logic        res_event_valid;
    result_t     res;
    logic        out_free;

    logic        m_valid_reg;
    result_t     m_data_reg;
    logic        m_evalid_reg;

    always_comb begin
        item.action       = action_t'(s_tuser);
        item.move_dx      = s_tdata[31:0];
        item.move_dy      = s_tdata[63:32];
        item.button_index = s_tdata[71:64];
        item.button_down  = s_tdata[72];
        item.wheel_step   = s_tdata[80:73];
        item.new_x        = s_tdata[112:81];
        item.new_y        = s_tdata[144:113];
    end

    assign out_free = !m_valid_reg || m_tready;

    meaq_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_item         (item),
        .in_ready        (s_tready),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res_event_valid (res_event_valid),
        .res             (res),
        .ram_req         (ram_req),
        .ram_rdata       (ram_rdata)
    );

    meaq_ring_ram u_ring (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_data_reg   <= res;
            m_evalid_reg <= res_event_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_evalid_reg;

endmodule

// File: sv/meaq_ring_ram.sv
// Event ring storage: one write port, one read port, registered read data.
// Depends on meaq_pkg.
module meaq_ring_ram
    import meaq_pkg::*;
(
    input  logic        aclk,
    input  ram_req_t    req,
    output ring_entry_t rdata
);

    ring_entry_t mem [QUEUE_DEPTH];
    ring_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/meaq_core.sv
// Item sequencer: position, deltas, button mask and ring pointers.
// Issues ring writes and reads; depends on meaq_pkg.
module meaq_core
    import meaq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        in_ready,
    input  logic        out_free,
    output logic        res_valid,
    output logic        res_event_valid,
    output result_t     res,
    output ram_req_t    ram_req,
    input  ring_entry_t ram_rdata
);

    localparam ptr_t LAST_PTR = ptr_t'(QUEUE_DEPTH - 1);

    state_t      st_reg, st_next;
    logic [31:0] pos_x_reg, pos_x_next;
    logic [31:0] pos_y_reg, pos_y_next;
    logic [31:0] last_dx_reg, last_dx_next;
    logic [31:0] last_dy_reg, last_dy_next;
    btn_mask_t   held_reg, held_next;
    ptr_t        wr_reg, wr_next;
    ptr_t        rd_reg, rd_next;
    logic        hit_reg, hit_next;

    ptr_t        wr_adv, rd_adv;
    logic        push_en;
    logic [31:0] push_dx, push_dy;
    logic [7:0]  push_wheel;
    btn_mask_t   btn_bit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            last_dx_reg <= '0;
            last_dy_reg <= '0;
            held_reg    <= '0;
            wr_reg      <= '0;
            rd_reg      <= '0;
            hit_reg     <= 1'b0;
        end else begin
            st_reg      <= st_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            last_dx_reg <= last_dx_next;
            last_dy_reg <= last_dy_next;
            held_reg    <= held_next;
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            hit_reg     <= hit_next;
        end
    end

    assign wr_adv  = (wr_reg == LAST_PTR) ? '0 : wr_reg + ptr_t'(1);
    assign rd_adv  = (rd_reg == LAST_PTR) ? '0 : rd_reg + ptr_t'(1);
    assign btn_bit = btn_mask_t'(1) << in_item.button_index;

    always_comb begin
        st_next      = st_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        last_dx_next = last_dx_reg;
        last_dy_next = last_dy_reg;
        held_next    = held_reg;
        wr_next      = wr_reg;
        rd_next      = rd_reg;
        hit_next     = hit_reg;
        push_en      = 1'b0;
        push_dx      = '0;
        push_dy      = '0;
        push_wheel   = '0;
        ram_req      = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        unique case (st_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    st_next  = ST_RESP;
                    hit_next = 1'b0;
                    case (in_item.action)
                        ACT_MOTION: begin
                            pos_x_next   = pos_x_reg + in_item.move_dx;
                            pos_y_next   = pos_y_reg + in_item.move_dy;
                            last_dx_next = in_item.move_dx;
                            last_dy_next = in_item.move_dy;
                            push_en      = 1'b1;
                            push_dx      = in_item.move_dx;
                            push_dy      = in_item.move_dy;
                        end
                        ACT_BUTTON: begin
                            if (32'(in_item.button_index) < BUTTON_COUNT) begin
                                held_next = in_item.button_down ? (held_reg | btn_bit)
                                                                : (held_reg & ~btn_bit);
                                push_en   = 1'b1;
                            end
                        end
                        ACT_WHEEL: begin
                            push_en    = 1'b1;
                            push_wheel = in_item.wheel_step;
                        end
                        ACT_SET_POS: begin
                            pos_x_next = in_item.new_x;
                            pos_y_next = in_item.new_y;
                        end
                        ACT_POLL: begin
                            if (rd_reg != wr_reg) begin
                                hit_next       = 1'b1;
                                ram_req.re     = 1'b1;
                                ram_req.raddr  = rd_reg;
                                rd_next        = rd_adv;
                            end
                        end
                        default: ;
                    endcase

                    // full ring drops the event
                    if (push_en && (wr_adv != rd_reg)) begin
                        ram_req.we            = 1'b1;
                        ram_req.waddr         = wr_reg;
                        ram_req.wdata.x       = pos_x_next;
                        ram_req.wdata.y       = pos_y_next;
                        ram_req.wdata.dx      = push_dx;
                        ram_req.wdata.dy      = push_dy;
                        ram_req.wdata.wheel   = push_wheel;
                        ram_req.wdata.buttons = 8'(held_next);
                        wr_next               = wr_adv;
                    end
                end
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res                 = '0;
        res_event_valid     = hit_reg;
        if (hit_reg) begin
            res.event_x       = ram_rdata.x;
            res.event_y       = ram_rdata.y;
            res.event_dx      = ram_rdata.dx;
            res.event_dy      = ram_rdata.dy;
            res.event_wheel   = ram_rdata.wheel;
            res.event_buttons = ram_rdata.buttons;
        end
        res.current_x   = pos_x_reg;
        res.current_y   = pos_y_reg;
        res.last_dx     = last_dx_reg;
        res.last_dy     = last_dy_reg;
        res.buttons_now = 8'(held_reg);
    end

endmodule
